@@ rtl/collision_rect_hit_table_top_defines.svh @@
// assertion macros shared by the rect hit table modules
`ifndef COLLISION_RECT_HIT_TABLE_TOP_DEFINES_SVH
`define COLLISION_RECT_HIT_TABLE_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CRHT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define CRHT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/crht_pkg.sv @@
// shared types and codes of the rect hit table
package crht_pkg;

    localparam int COORD_W   = 16;
    localparam int SIZE_W    = 15;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 2;
    localparam int IDX_OUT_W = 6;
    localparam int CNT_OUT_W = 7;

    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_LOCATE = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    // read address select
    localparam logic [1:0] RD_ZERO = 2'd0;
    localparam logic [1:0] RD_NEXT = 2'd1;
    localparam logic [1:0] RD_SKIP = 2'd2;

    // result index select
    localparam logic [1:0] IDX_ZERO  = 2'd0;
    localparam logic [1:0] IDX_PTR   = 2'd1;
    localparam logic [1:0] IDX_COUNT = 2'd2;

    typedef struct packed {
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [SIZE_W-1:0]  w;
        logic [SIZE_W-1:0]  h;
    } t_entry;

    typedef struct packed {
        logic                capture;
        logic                rd_en;
        logic [1:0]          rd_sel;
        logic                ptr_clr;
        logic                ptr_inc;
        logic                wr_add;
        logic                wr_shift;
        logic                cnt_inc;
        logic                cnt_dec;
        logic                res_load;
        logic [STATUS_W-1:0] res_status;
        logic [1:0]          res_idx_sel;
        logic                out_load;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            full;
        logic            empty;
        logic            hit;
        logic            scan_last;
        logic            shift_last;
    } t_stat;

endpackage

@@ rtl/collision_rect_hit_table_top.sv @@
// top level of the rectangle hit table
//
// keeps an ordered table of rectangles (left, top, width, height) in one ram
// input channel: i_in_valid / o_in_ready carries one word with an operation
//   add appends the rectangle, locate finds the first one that strictly holds
//   the point, delete removes that first one and closes the gap in order
// output channel: o_out_valid / i_out_ready carries one result word per input
//   word: status, entry index and entry count after the operation
// steps from accept to result, with the receiver ready:
//   add, unused code or empty table: decode, then load the output register
//   locate: decode, scan from index 0 to the first hit or the last entry, then load
//   delete: as locate, but after a hit each later entry first moves down one place
// the table ram is scanned one entry per cycle through its registered read
//   port and the delete moves one entry per cycle
// a new word is taken only in the idle state that follows the load of the
//   previous result into the output register, so one word is worked at a time
// if the receiver stalls, the result waits in the output register and the
//   block keeps taking and working the next word; it holds that result until
//   the register frees up
// reset clears the entry count and both channels; table contents are not cleared
module collision_rect_hit_table_top #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [crht_pkg::OP_W-1:0]           i_operation,
    input  logic signed [crht_pkg::COORD_W-1:0] i_point_x,
    input  logic signed [crht_pkg::COORD_W-1:0] i_point_y,
    input  logic [crht_pkg::SIZE_W-1:0]         i_rect_width,
    input  logic [crht_pkg::SIZE_W-1:0]         i_rect_height,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [crht_pkg::STATUS_W-1:0]       o_status,
    output logic [crht_pkg::IDX_OUT_W-1:0]      o_entry_index,
    output logic [crht_pkg::CNT_OUT_W-1:0]      o_entry_count
);

    crht_pkg::t_cmd  cmd;
    crht_pkg::t_stat stat;

    // sequencer for decode, scan, shift and result handoff
    crht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // table storage, containment compare and result registers
    crht_dp #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_operation  (i_operation),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .i_rect_width (i_rect_width),
        .i_rect_height(i_rect_height),
        .o_status     (o_status),
        .o_entry_index(o_entry_index),
        .o_entry_count(o_entry_count)
    );

endmodule

@@ rtl/crht_ram.sv @@
// generic simple dual-port ram with registered read
module crht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/crht_dp.sv @@
// datapath: captured word, table ram, scan pointer, count and result registers
`include "collision_rect_hit_table_top_defines.svh"

module crht_dp #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  crht_pkg::t_cmd                      i_cmd,
    output crht_pkg::t_stat                     o_stat,
    input  logic [crht_pkg::OP_W-1:0]           i_operation,
    input  logic signed [crht_pkg::COORD_W-1:0] i_point_x,
    input  logic signed [crht_pkg::COORD_W-1:0] i_point_y,
    input  logic [crht_pkg::SIZE_W-1:0]         i_rect_width,
    input  logic [crht_pkg::SIZE_W-1:0]         i_rect_height,
    output logic [crht_pkg::STATUS_W-1:0]       o_status,
    output logic [crht_pkg::IDX_OUT_W-1:0]      o_entry_index,
    output logic [crht_pkg::CNT_OUT_W-1:0]      o_entry_count
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int EW = $bits(crht_pkg::t_entry);

    // captured word
    logic [crht_pkg::OP_W-1:0]    r_op;
    logic [crht_pkg::COORD_W-1:0] r_x;
    logic [crht_pkg::COORD_W-1:0] r_y;
    logic [crht_pkg::SIZE_W-1:0]  r_w;
    logic [crht_pkg::SIZE_W-1:0]  r_h;

    logic [CW-1:0] r_count, n_count;
    logic [IW-1:0] r_ptr, n_ptr;

    logic [crht_pkg::STATUS_W-1:0]  r_res_status;
    logic [IW-1:0]                  r_res_idx;
    logic [crht_pkg::STATUS_W-1:0]  r_out_status;
    logic [crht_pkg::IDX_OUT_W-1:0] r_out_idx;
    logic [crht_pkg::CNT_OUT_W-1:0] r_out_count;

    logic            wr_en;
    logic [IW-1:0]   wr_addr;
    crht_pkg::t_entry wr_entry;
    logic [IW-1:0]   rd_addr;
    logic [EW-1:0]   rd_data;
    crht_pkg::t_entry rd_entry;

    logic [CW:0] right_edge;
    logic [CW:0] bottom_edge;
    logic [16:0] right_sum;
    logic [16:0] bottom_sum;
    logic        hit;

    // table ram, one entry per rectangle
    crht_ram #(
        .WIDTH(EW),
        .DEPTH(TABLE_DEPTH)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_entry),
        .i_rd_en  (i_cmd.rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    assign rd_entry = crht_pkg::t_entry'(rd_data);

    always_comb begin
        case (i_cmd.rd_sel)
            crht_pkg::RD_ZERO: rd_addr = '0;
            crht_pkg::RD_NEXT: rd_addr = r_ptr + IW'(1);
            crht_pkg::RD_SKIP: rd_addr = r_ptr + IW'(2);
            default:           rd_addr = '0;
        endcase
    end

    // add writes the captured word at the tail, shift moves the read entry down
    assign wr_en   = i_cmd.wr_add || i_cmd.wr_shift;
    assign wr_addr = i_cmd.wr_add ? r_count[IW-1:0] : r_ptr;
    always_comb begin
        if (i_cmd.wr_add) begin
            wr_entry.left = r_x;
            wr_entry.top  = r_y;
            wr_entry.w    = r_w;
            wr_entry.h    = r_h;
        end else begin
            wr_entry = rd_entry;
        end
    end

    // strict containment, edges formed at 17 bits so they never wrap
    assign right_sum  = {rd_entry.left[15], rd_entry.left} + {2'b00, rd_entry.w};
    assign bottom_sum = {rd_entry.top[15], rd_entry.top} + {2'b00, rd_entry.h};
    assign hit = ($signed(rd_entry.left) < $signed(r_x))
              && ($signed(right_sum) > $signed({r_x[15], r_x}))
              && ($signed(rd_entry.top) < $signed(r_y))
              && ($signed(bottom_sum) > $signed({r_y[15], r_y}));

    assign right_edge  = {1'b0, CW'(r_ptr)} + (CW + 1)'(1);
    assign bottom_edge = {1'b0, CW'(r_ptr)} + (CW + 1)'(2);

    assign o_stat.op         = r_op;
    assign o_stat.full       = (r_count == CW'(TABLE_DEPTH));
    assign o_stat.empty      = (r_count == '0);
    assign o_stat.hit        = hit;
    assign o_stat.scan_last  = (right_edge == {1'b0, r_count});
    assign o_stat.shift_last = (bottom_edge == {1'b0, r_count});

    always_comb begin
        n_count = r_count;
        if (i_cmd.cnt_inc) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.cnt_dec) begin
            n_count = r_count - CW'(1);
        end
        n_ptr = r_ptr;
        if (i_cmd.ptr_clr) begin
            n_ptr = '0;
        end else if (i_cmd.ptr_inc) begin
            n_ptr = r_ptr + IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ptr   <= '0;
        end else begin
            r_count <= n_count;
            r_ptr   <= n_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op <= i_operation;
            r_x  <= i_point_x;
            r_y  <= i_point_y;
            r_w  <= i_rect_width;
            r_h  <= i_rect_height;
        end
        if (i_cmd.res_load) begin
            r_res_status <= i_cmd.res_status;
            case (i_cmd.res_idx_sel)
                crht_pkg::IDX_PTR:   r_res_idx <= r_ptr;
                crht_pkg::IDX_COUNT: r_res_idx <= r_count[IW-1:0];
                default:             r_res_idx <= '0;
            endcase
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_idx    <= crht_pkg::IDX_OUT_W'(r_res_idx);
            r_out_count  <= crht_pkg::CNT_OUT_W'(r_count);
        end
    end

    assign o_status      = r_out_status;
    assign o_entry_index = r_out_idx;
    assign o_entry_count = r_out_count;

    `CRHT_ASSERT_NOW(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CW'(TABLE_DEPTH),
        "entry count above table depth")
    `CRHT_ASSERT_NOW(a_inc_not_full, i_clk, i_rst_n, i_cmd.cnt_inc, !o_stat.full,
        "append into a full table")
    `CRHT_ASSERT_NOW(a_dec_not_empty, i_clk, i_rst_n, i_cmd.cnt_dec, !o_stat.empty,
        "removal from an empty table")

endmodule

@@ rtl/crht_ctrl.sv @@
// controller: sequences add, scan and shift, owns the handshakes
`include "collision_rect_hit_table_top_defines.svh"

module crht_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  crht_pkg::t_stat i_stat,
    output crht_pkg::t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    crht_pkg::t_cmd cmd;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.capture = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                cmd.res_status  = crht_pkg::ST_NONE;
                cmd.res_idx_sel = crht_pkg::IDX_ZERO;
                n_state         = S_DONE;
                case (i_stat.op)
                    crht_pkg::OP_ADD: begin
                        cmd.res_load = 1'b1;
                        if (i_stat.full) begin
                            cmd.res_status = crht_pkg::ST_FULL;
                        end else begin
                            cmd.wr_add      = 1'b1;
                            cmd.cnt_inc     = 1'b1;
                            cmd.res_status  = crht_pkg::ST_OK;
                            cmd.res_idx_sel = crht_pkg::IDX_COUNT;
                        end
                    end
                    crht_pkg::OP_LOCATE, crht_pkg::OP_DELETE: begin
                        if (i_stat.empty) begin
                            cmd.res_load = 1'b1;
                        end else begin
                            cmd.rd_en   = 1'b1;
                            cmd.rd_sel  = crht_pkg::RD_ZERO;
                            cmd.ptr_clr = 1'b1;
                            n_state     = S_SCAN;
                        end
                    end
                    default: begin
                        cmd.res_load = 1'b1;
                    end
                endcase
            end
            S_SCAN: begin
                if (i_stat.hit) begin
                    cmd.res_load    = 1'b1;
                    cmd.res_status  = crht_pkg::ST_OK;
                    cmd.res_idx_sel = crht_pkg::IDX_PTR;
                    n_state         = S_DONE;
                    if (i_stat.op == crht_pkg::OP_DELETE) begin
                        if (i_stat.scan_last) begin
                            cmd.cnt_dec = 1'b1;
                        end else begin
                            // fetch the entry above the hit, ptr stays on the hole
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = crht_pkg::RD_NEXT;
                            n_state    = S_SHIFT;
                        end
                    end
                end else if (i_stat.scan_last) begin
                    cmd.res_load    = 1'b1;
                    cmd.res_status  = crht_pkg::ST_NONE;
                    cmd.res_idx_sel = crht_pkg::IDX_ZERO;
                    n_state         = S_DONE;
                end else begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_sel  = crht_pkg::RD_NEXT;
                    cmd.ptr_inc = 1'b1;
                end
            end
            S_SHIFT: begin
                cmd.wr_shift = 1'b1;
                cmd.ptr_inc  = 1'b1;
                if (i_stat.shift_last) begin
                    cmd.cnt_dec = 1'b1;
                    n_state     = S_DONE;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = crht_pkg::RD_SKIP;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_valid = cmd.out_load || (r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    `CRHT_ASSERT_NEXT(a_accept_decode, i_clk, i_rst_n, i_in_valid && o_in_ready,
        r_state == S_DECODE, "accepted word not decoded")
    `CRHT_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, cmd.out_load,
        !r_out_valid || i_out_ready, "pending result overwritten")
    `CRHT_ASSERT_NEXT(a_shift_runs, i_clk, i_rst_n,
        r_state == S_SHIFT && !i_stat.shift_last, r_state == S_SHIFT,
        "shift left early")

endmodule
